// ===== design/multi_button_debouncer_assert.svh =====
// Assertion macros for the multi-button debouncer.
// Used by the lane and top-level files; no other dependencies.
`ifndef MULTI_BUTTON_DEBOUNCER_ASSERT_SVH
`define MULTI_BUTTON_DEBOUNCER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define DBN_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define DBN_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);
`else
`define DBN_ASSERT(label, prop, msg)
`define DBN_ASSERT_NEXT(label, cond, prop, msg)
`endif

`endif

// ===== design/dbn_pkg.sv =====
// Package for the multi-button debouncer: sizes, phase codes and the
// structs passed between lanes, merge stage and top level. No dependencies.
package dbn_pkg;

    localparam int NUM_BUTTONS = 8;
    localparam int PIN_W       = 8;
    localparam int QIDX_W      = 3;
    localparam int TICKS_W     = 16;

    localparam logic [TICKS_W-1:0] DEBOUNCE_RESET = 16'd20;

    typedef enum logic [1:0] {
        PH_RELEASED     = 2'd0,
        PH_CONF_PRESS   = 2'd1,
        PH_PRESSED      = 2'd2,
        PH_CONF_RELEASE = 2'd3
    } t_phase;

    typedef struct packed {
        logic advance;
        logic down;
        logic clear;
    } t_lane_ctrl;

    typedef struct packed {
        logic flag;
        logic level;
    } t_lane_stat;

    typedef struct packed {
        logic             query_pressed;
        logic [PIN_W-1:0] pressed_flags;
        logic [PIN_W-1:0] debounced_levels;
    } t_result;

endpackage

// ===== design/dbn_lane.sv =====
// One button's debounce state machine with its own tick counter and flag.
// Depends on dbn_pkg and multi_button_debouncer_assert.svh.
`include "multi_button_debouncer_assert.svh"

module dbn_lane
    import dbn_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [TICKS_W-1:0] i_debounce_ticks,
    input  t_lane_ctrl         i_ctrl,
    output t_lane_stat         o_stat
);

    t_phase             r_phase, n_phase;
    logic [TICKS_W-1:0] r_count, n_count;
    logic               r_flag, n_flag_set;
    logic [TICKS_W:0]   count_inc;
    logic               done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_RELEASED;
            r_count <= '0;
            r_flag  <= 1'b0;
        end else if (i_ctrl.advance) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_flag  <= n_flag_set & ~i_ctrl.clear;
        end
    end

    assign count_inc = {1'b0, r_count} + {{TICKS_W{1'b0}}, 1'b1};
    assign done      = count_inc >= {1'b0, i_debounce_ticks};

    always_comb begin
        n_phase    = r_phase;
        n_count    = r_count;
        n_flag_set = r_flag;
        unique case (r_phase)
            PH_RELEASED: begin
                if (i_ctrl.down) begin
                    n_phase = PH_CONF_PRESS;
                    n_count = '0;
                end
            end
            PH_CONF_PRESS: begin
                n_count = count_inc[TICKS_W-1:0];
                if (done) begin
                    n_count = '0;
                    if (i_ctrl.down) begin
                        n_phase    = PH_PRESSED;
                        n_flag_set = 1'b1;
                    end else begin
                        n_phase = PH_RELEASED;
                    end
                end
            end
            PH_PRESSED: begin
                if (!i_ctrl.down) begin
                    n_phase = PH_CONF_RELEASE;
                    n_count = '0;
                end
            end
            PH_CONF_RELEASE: begin
                n_count = count_inc[TICKS_W-1:0];
                if (done) begin
                    n_count = '0;
                    n_phase = i_ctrl.down ? PH_PRESSED : PH_RELEASED;
                end
            end
            default: begin
                n_phase = PH_RELEASED;
            end
        endcase
    end

    assign o_stat.flag  = n_flag_set;
    assign o_stat.level = (n_phase == PH_PRESSED) || (n_phase == PH_CONF_RELEASE);

    `DBN_ASSERT(a_count_idle, ((r_phase == PH_RELEASED) || (r_phase == PH_PRESSED)) |-> (r_count == '0), "counter not zero in a settled phase")
    `DBN_ASSERT(a_flag_source, $rose(r_flag) |-> ($past(r_phase) == PH_CONF_PRESS), "flag set outside a press commit")

endmodule

// ===== design/dbn_merge.sv =====
// Merge stage: gathers lane flags and levels and decodes the query.
// Depends on dbn_pkg.
module dbn_merge
    import dbn_pkg::*;
(
    input  t_lane_stat [NUM_BUTTONS-1:0] i_stat,
    input  logic                         i_query_valid,
    input  logic [QIDX_W-1:0]            i_query_index,
    output logic [NUM_BUTTONS-1:0]       o_clear,
    output t_result                      o_result
);

    always_comb begin
        o_clear  = '0;
        o_result = '0;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            if (b < PIN_W) begin
                o_clear[b] = i_query_valid && (i_query_index == QIDX_W'(b));
                o_result.pressed_flags[b]    = i_stat[b].flag;
                o_result.debounced_levels[b] = i_stat[b].level;
                if (o_clear[b]) begin
                    o_result.query_pressed = i_stat[b].flag;
                end
            end
        end
    end

endmodule

// ===== design/multi_button_debouncer.sv =====
// Multi-button debouncer top level: config register, lanes, merge, output skid.
// Depends on dbn_pkg, dbn_lane, dbn_merge and multi_button_debouncer_assert.svh.
//
// One transaction per clock while o_ready is high: each accepted sample updates
// every button lane in the same cycle, and its result is registered into the
// output register, or into the skid entry while the output is stalled. A two-entry
// output stage keeps input accepting one more sample during an output stall.
// Write debounce_ticks only while idle; a value of zero behaves as one.
`include "multi_button_debouncer_assert.svh"

module multi_button_debouncer
    import dbn_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [TICKS_W-1:0] i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [PIN_W-1:0]   i_pin_levels,
    input  logic               i_query_valid,
    input  logic [QIDX_W-1:0]  i_query_index,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_query_pressed,
    output logic [PIN_W-1:0]   o_pressed_flags,
    output logic [PIN_W-1:0]   o_debounced_levels
);

    logic [TICKS_W-1:0]           r_debounce_ticks;
    t_lane_ctrl [NUM_BUTTONS-1:0] lane_ctrl;
    t_lane_stat [NUM_BUTTONS-1:0] lane_stat;
    logic [NUM_BUTTONS-1:0]       lane_clear;
    t_result                      result;
    logic                         accept_in, out_take;
    t_result                      r_out, n_out, r_skid, n_skid;
    logic                         r_out_valid, n_out_valid, r_skid_valid, n_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks <= DEBOUNCE_RESET;
        end else if (i_cfg_we) begin
            r_debounce_ticks <= i_cfg_data;
        end
    end

    assign o_ready   = !r_skid_valid;
    assign accept_in = i_valid && o_ready;
    assign out_take  = r_out_valid && i_ready;

    for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
        if (b < PIN_W) begin : g_pin
            assign lane_ctrl[b].down = ~i_pin_levels[b];
        end else begin : g_nopin
            assign lane_ctrl[b].down = 1'b0;
        end
        assign lane_ctrl[b].advance = accept_in;
        assign lane_ctrl[b].clear   = lane_clear[b];

        dbn_lane u_lane (
            .i_clk            (i_clk),
            .i_rst_n          (i_rst_n),
            .i_debounce_ticks (r_debounce_ticks),
            .i_ctrl           (lane_ctrl[b]),
            .o_stat           (lane_stat[b])
        );
    end

    dbn_merge u_merge (
        .i_stat        (lane_stat),
        .i_query_valid (i_query_valid),
        .i_query_index (i_query_index),
        .o_clear       (lane_clear),
        .o_result      (result)
    );

    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_skid       = r_skid;
        n_skid_valid = r_skid_valid;
        if (r_skid_valid) begin
            if (out_take) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (accept_in) begin
            if (!r_out_valid || out_take) begin
                n_out       = result;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = result;
                n_skid_valid = 1'b1;
            end
        end else if (out_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid            = r_out_valid;
    assign o_query_pressed    = r_out.query_pressed;
    assign o_pressed_flags    = r_out.pressed_flags;
    assign o_debounced_levels = r_out.debounced_levels;

    `DBN_ASSERT(a_skid_order, r_skid_valid |-> r_out_valid, "skid entry held without output entry")
    `DBN_ASSERT_NEXT(a_skid_drain, r_skid_valid && i_ready, r_out_valid && !r_skid_valid, "skid entry not moved to output")

endmodule

// ===== dv/multi_button_debouncer_tb.sv =====
// Self-checking testbench for multi_button_debouncer: directed table, then random phases.
// Depends on dbn_pkg and the design sources; predicts results a table row does not give.
`timescale 1ns / 1ps

module multi_button_debouncer_tb;
    import dbn_pkg::*;

    typedef enum bit {ROW_ITEM, ROW_CFG} t_row_kind;
    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle;

    typedef struct packed {
        t_row_kind          kind;
        logic [TICKS_W-1:0] ticks;
        logic [PIN_W-1:0]   pins;
        logic               qv;
        logic [QIDX_W-1:0]  qi;
        bit                 has_exp;
        t_result            exp;
    } t_row;

    localparam int CYCLE_LIMIT     = 300000;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int DRAIN_CYCLES    = 6;
    localparam int NUM_ROWS        = 25;
    localparam int NUM_RUNS        = 8;

    localparam t_row DIRECTED [NUM_ROWS] = '{
        '{ROW_ITEM, 16'd0,     8'hFF, 1'b0, 3'd0, 1'b1, '{1'b0, 8'h00, 8'h00}},
        '{ROW_ITEM, 16'd0,     8'h00, 1'b1, 3'd7, 1'b1, '{1'b0, 8'h00, 8'h00}},
        '{ROW_CFG,  16'd0,     8'hFF, 1'b0, 3'd0, 1'b0, '0},
        '{ROW_ITEM, 16'd0,     8'h00, 1'b0, 3'd0, 1'b1, '{1'b0, 8'hFF, 8'hFF}},
        '{ROW_ITEM, 16'd0,     8'h00, 1'b1, 3'd0, 1'b1, '{1'b1, 8'hFF, 8'hFF}},
        '{ROW_ITEM, 16'd0,     8'h00, 1'b1, 3'd0, 1'b1, '{1'b0, 8'hFE, 8'hFF}},
        '{ROW_ITEM, 16'd0,     8'hFF, 1'b1, 3'd7, 1'b0, '0},
        '{ROW_ITEM, 16'd0,     8'h00, 1'b0, 3'd0, 1'b0, '0},
        '{ROW_ITEM, 16'd0,     8'hFF, 1'b0, 3'd0, 1'b0, '0},
        '{ROW_ITEM, 16'd0,     8'hFF, 1'b0, 3'd0, 1'b0, '0},
        '{ROW_ITEM, 16'd0,     8'h55, 1'b1, 3'd7, 1'b0, '0},
        '{ROW_ITEM, 16'd0,     8'h55, 1'b1, 3'd2, 1'b0, '0},
        '{ROW_ITEM, 16'd0,     8'hAA, 1'b1, 3'd1, 1'b0, '0},
        '{ROW_CFG,  16'd3,     8'hFF, 1'b0, 3'd0, 1'b0, '0},
        '{ROW_ITEM, 16'd0,     8'hF0, 1'b0, 3'd0, 1'b0, '0},
        '{ROW_ITEM, 16'd0,     8'hFF, 1'b0, 3'd0, 1'b0, '0},
        '{ROW_ITEM, 16'd0,     8'hFF, 1'b0, 3'd0, 1'b0, '0},
        '{ROW_ITEM, 16'd0,     8'hF0, 1'b1, 3'd5, 1'b0, '0},
        '{ROW_CFG,  16'hFFFF,  8'hFF, 1'b0, 3'd0, 1'b0, '0},
        '{ROW_ITEM, 16'd0,     8'h0F, 1'b0, 3'd0, 1'b0, '0},
        '{ROW_ITEM, 16'd0,     8'h0F, 1'b1, 3'd6, 1'b0, '0},
        '{ROW_ITEM, 16'd0,     8'hFF, 1'b1, 3'd3, 1'b0, '0},
        '{ROW_CFG,  16'd1,     8'hFF, 1'b0, 3'd0, 1'b0, '0},
        '{ROW_ITEM, 16'd0,     8'hFF, 1'b0, 3'd0, 1'b0, '0},
        '{ROW_ITEM, 16'd0,     8'h00, 1'b1, 3'd4, 1'b0, '0}
    };

    localparam t_idle RUN_IDLE [NUM_RUNS] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
                                              IDLE_NONE, IDLE_RECV, IDLE_SEND, IDLE_BOTH};
    localparam int RUN_TICKS [NUM_RUNS] = '{2, 1, 5, 20, 65535, 3, 4, 0};
    localparam int RUN_ITEMS [NUM_RUNS] = '{150, 150, 150, 150, 40, 100, 100, 60};

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [TICKS_W-1:0] i_cfg_data;
    logic               i_valid;
    logic               o_ready;
    logic [PIN_W-1:0]   i_pin_levels;
    logic               i_query_valid;
    logic [QIDX_W-1:0]  i_query_index;
    logic               o_valid;
    logic               i_ready;
    logic               o_query_pressed;
    logic [PIN_W-1:0]   o_pressed_flags;
    logic [PIN_W-1:0]   o_debounced_levels;

    t_phase             btn_phase [NUM_BUTTONS];
    logic [TICKS_W-1:0] btn_count [NUM_BUTTONS];
    logic               btn_flag  [NUM_BUTTONS];
    logic [TICKS_W-1:0] debounce_len;
    t_result            pending_results [$];

    logic    took_item = 1'b0;
    bit      cur_has_exp = 1'b0;
    t_result cur_exp = '0;
    bit      send_idle = 1'b0;
    bit      recv_stall = 1'b0;
    int      idle_pct = 86;
    bit      hold_req = 1'b0;
    int      cycle_count = 0;
    int      errors = 0;

    multi_button_debouncer i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_pin_levels       (i_pin_levels),
        .i_query_valid      (i_query_valid),
        .i_query_index      (i_query_index),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_query_pressed    (o_query_pressed),
        .o_pressed_flags    (o_pressed_flags),
        .o_debounced_levels (o_debounced_levels)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit confirm_elapsed(input int b);
        logic [TICKS_W:0] next;
        next = {1'b0, btn_count[b]} + 1'b1;
        btn_count[b] = next[TICKS_W-1:0];
        return next >= {1'b0, debounce_len};
    endfunction

    function automatic t_result debounce_tick(input logic [PIN_W-1:0] pins, input logic qv,
                                              input logic [QIDX_W-1:0] qi);
        t_result r;
        logic    down;
        r = '0;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            down = !pins[b];
            case (btn_phase[b])
                PH_RELEASED: begin
                    if (down) begin
                        btn_count[b] = '0;
                        btn_phase[b] = PH_CONF_PRESS;
                    end
                end
                PH_CONF_PRESS: begin
                    if (confirm_elapsed(b)) begin
                        btn_phase[b] = down ? PH_PRESSED : PH_RELEASED;
                        if (down) btn_flag[b] = 1'b1;
                        btn_count[b] = '0;
                    end
                end
                PH_PRESSED: begin
                    if (!down) begin
                        btn_count[b] = '0;
                        btn_phase[b] = PH_CONF_RELEASE;
                    end
                end
                default: begin
                    if (confirm_elapsed(b)) begin
                        btn_phase[b] = down ? PH_PRESSED : PH_RELEASED;
                        btn_count[b] = '0;
                    end
                end
            endcase
            r.pressed_flags[b] = btn_flag[b];
            r.debounced_levels[b] = (btn_phase[b] == PH_PRESSED) ||
                                    (btn_phase[b] == PH_CONF_RELEASE);
        end
        if (qv) begin
            r.query_pressed = btn_flag[qi];
            btn_flag[qi] = 1'b0;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result predicted;
        t_result want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("multi_button_debouncer: mismatch");
            $finish;
        end else if (i_rst_n) begin
            if (i_cfg_we) debounce_len = i_cfg_data;
            took_item <= i_valid && o_ready;
            if (i_valid && o_ready) begin
                predicted = debounce_tick(i_pin_levels, i_query_valid, i_query_index);
                pending_results.push_back(cur_has_exp ? cur_exp : predicted);
            end
            if (o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result transaction with nothing pending");
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_query_pressed !== want.query_pressed) begin
                        $error("query_pressed: expected %0d, got %0d",
                               want.query_pressed, o_query_pressed);
                        errors++;
                    end
                    if (o_pressed_flags !== want.pressed_flags) begin
                        $error("pressed_flags: expected %02h, got %02h",
                               want.pressed_flags, o_pressed_flags);
                        errors++;
                    end
                    if (o_debounced_levels !== want.debounced_levels) begin
                        $error("debounced_levels: expected %02h, got %02h",
                               want.debounced_levels, o_debounced_levels);
                        errors++;
                    end
                end
            end
        end
    end

    // Receiver: random stalls per phase, plus one long hold-off to back up the input.
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_ready <= 1'b0;
                hold_left--;
            end else if (hold_req && !hold_done) begin
                hold_left = HOLD_OFF_CYCLES;
                hold_done = 1'b1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= !(recv_stall && $urandom_range(99) < idle_pct);
            end
        end
    end

    task automatic send_item(input logic [PIN_W-1:0] pins, input logic qv,
                             input logic [QIDX_W-1:0] qi, input bit has_exp,
                             input t_result exp);
        while (send_idle && $urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_pin_levels  <= pins;
        i_query_valid <= qv;
        i_query_index <= qi;
        cur_has_exp = has_exp;
        cur_exp     = exp;
        do @(negedge i_clk); while (!took_item);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_ticks(input logic [TICKS_W-1:0] value);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        logic [PIN_W-1:0]   held;
        logic [PIN_W-1:0]   pins;
        logic [TICKS_W-1:0] ticks;
        int                 churn;
        int                 roll;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        i_valid       = 1'b0;
        i_pin_levels  = '1;
        i_query_valid = 1'b0;
        i_query_index = '0;
        debounce_len  = DEBOUNCE_RESET;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            btn_phase[b] = PH_RELEASED;
            btn_count[b] = '0;
            btn_flag[b]  = 1'b0;
        end
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < NUM_ROWS; r++) begin
            if (DIRECTED[r].kind == ROW_CFG) begin
                write_ticks(DIRECTED[r].ticks);
            end else begin
                send_item(DIRECTED[r].pins, DIRECTED[r].qv, DIRECTED[r].qi,
                          DIRECTED[r].has_exp, DIRECTED[r].exp);
            end
        end

        for (int p = 0; p < NUM_RUNS; p++) begin
            ticks = (p == 6) ? TICKS_W'($urandom_range(8, 1)) : TICKS_W'(RUN_TICKS[p]);
            write_ticks(ticks);
            send_idle  = (RUN_IDLE[p] == IDLE_SEND) || (RUN_IDLE[p] == IDLE_BOTH);
            recv_stall = (RUN_IDLE[p] == IDLE_RECV) || (RUN_IDLE[p] == IDLE_BOTH);
            idle_pct   = (RUN_IDLE[p] == IDLE_BOTH) ? 14 : 86;
            if (p == 0) hold_req = 1'b1;
            churn = (ticks == 0) ? 4 : ((ticks > 20) ? 23 : int'(ticks) + 3);
            held = '1;
            for (int n = 0; n < RUN_ITEMS[p]; n++) begin
                if ($urandom_range(churn) == 0) held[$urandom_range(7)] ^= 1'b1;
                roll = $urandom_range(15);
                if (roll == 0) begin
                    pins = PIN_W'($urandom);
                end else if (roll < 3) begin
                    pins = held ^ (PIN_W'(1) << $urandom_range(7));
                end else begin
                    pins = held;
                end
                send_item(pins, $urandom_range(3) == 0, QIDX_W'($urandom_range(7)), 1'b0, '0);
            end
        end

        drain();
        if (errors == 0) begin
            $display("multi_button_debouncer: match");
        end else begin
            $display("multi_button_debouncer: mismatch");
        end
        $finish;
    end

endmodule
